/* src/led_color_run_decoder_macros.svh */
// Assertion shorthands shared by the checkers of this block.
// Every property is clocked on clock and switched off while reset is high.
`ifndef LED_COLOR_RUN_DECODER_MACROS_SVH
`define LED_COLOR_RUN_DECODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCRD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lcrd_pkg.sv */
`default_nettype none

package lcrd_pkg;

   // Input item: one byte of the compressed command buffer
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in_buffer;
   } req_type;

   // Result item: one pad write
   typedef struct packed {
      logic [5:0] pad_index;
      logic [6:0] red_level;
      logic [6:0] green_level;
      logic [6:0] blue_level;
      logic       last_of_run;
   } rsp_type;

   // Expansion kinds of a position byte
   typedef logic [2:0] kind_type;

   localparam kind_type KIND_SINGLE = 3'd0;  // one pad
   localparam kind_type KIND_PAIR   = 3'd1;  // pad and its mirror
   localparam kind_type KIND_QUAD   = 3'd2;  // mirrored quad
   localparam kind_type KIND_COL    = 3'd3;  // 8-pad column
   localparam kind_type KIND_ROW    = 3'd4;  // 8-pad row

   // Classified position byte, passed from the parser to the expander
   typedef struct packed {
      kind_type   kind;
      logic [7:0] pos_byte;
      logic [6:0] red_level;
      logic [6:0] green_level;
      logic [6:0] blue_level;
   } job_type;

   // Queue between parser and expander
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

/* src/lcrd_front.sv */
`default_nettype none

module lcrd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lcrd_pkg::req_type req_data,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output lcrd_pkg::job_type     push_data
);

   // Parser phases
   localparam logic [2:0] PH_RED   = 3'd0;
   localparam logic [2:0] PH_GREEN = 3'd1;
   localparam logic [2:0] PH_BLUE  = 3'd2;
   localparam logic [2:0] PH_COUNT = 3'd3;
   localparam logic [2:0] PH_POS   = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [5:0] held_red_ff, held_red_in;
   logic [5:0] held_green_ff, held_green_in;
   logic [5:0] held_blue_ff, held_blue_in;
   logic [1:0] flag_ff, flag_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] left_dec;
   logic       accept;
   logic [7:0] d;

   // Channel value to drive level: zero stays zero, else value plus 2
   function automatic logic [6:0] level_of(input logic [5:0] c);
      level_of = (c == 6'd0) ? 7'd0 : ({1'b0, c} + 7'd2);
   endfunction

   // Sort a position byte into its expansion kind
   function automatic lcrd_pkg::kind_type kind_of(input logic [7:0] x);
      if (x[6:4] == 3'b110) begin
         kind_of = x[3] ? lcrd_pkg::KIND_COL : lcrd_pkg::KIND_ROW;
      end else if (!x[6]) begin
         kind_of = lcrd_pkg::KIND_SINGLE;
      end else if (!x[5]) begin
         kind_of = lcrd_pkg::KIND_PAIR;
      end else begin
         kind_of = lcrd_pkg::KIND_QUAD;
      end
   endfunction

   assign d         = req_data.data_byte;
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign left_dec  = left_ff - {7'd0, (left_ff != 8'd0)};

   // Position item toward the expander
   assign push_data.kind        = kind_of(d);
   assign push_data.pos_byte    = d;
   assign push_data.red_level   = level_of(held_red_ff);
   assign push_data.green_level = level_of(held_green_ff);
   assign push_data.blue_level  = level_of(held_blue_ff);

   // Parser next state
   always_comb begin
      phase_in      = phase_ff;
      held_red_in   = held_red_ff;
      held_green_in = held_green_ff;
      held_blue_in  = held_blue_ff;
      flag_in       = flag_ff;
      left_in       = left_ff;
      push_valid    = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_RED: begin
               held_red_in = d[5:0];
               flag_in     = {d[6], 1'b0};
               phase_in    = PH_GREEN;
            end
            PH_GREEN: begin
               held_green_in = d[5:0];
               flag_in       = {flag_ff[1], d[6]};
               phase_in      = PH_BLUE;
            end
            PH_BLUE: begin
               held_blue_in = d[5:0];
               if ({flag_ff, d[6]} == 3'd0) begin
                  phase_in = PH_COUNT;
               end else begin
                  left_in  = {5'd0, flag_ff, d[6]};
                  phase_in = PH_POS;
               end
            end
            PH_COUNT: begin
               left_in  = d;
               phase_in = (d == 8'd0) ? PH_RED : PH_POS;
            end
            PH_POS: begin
               push_valid = 1'b1;
               left_in    = left_dec;
               if (left_dec == 8'd0) begin
                  phase_in = PH_RED;
               end
            end
            default: begin
               phase_in = PH_RED;
            end
         endcase
         // End of buffer drops any open group
         if (req_data.last_in_buffer) begin
            phase_in = PH_RED;
            left_in  = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RED;
         held_red_ff   <= 6'd0;
         held_green_ff <= 6'd0;
         held_blue_ff  <= 6'd0;
         flag_ff       <= 2'd0;
         left_ff       <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         held_red_ff   <= held_red_in;
         held_green_ff <= held_green_in;
         held_blue_ff  <= held_blue_in;
         flag_ff       <= flag_in;
         left_ff       <= left_in;
      end
   end

endmodule

`default_nettype wire

/* src/lcrd_queue.sv */
`default_nettype none

module lcrd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire lcrd_pkg::job_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output lcrd_pkg::job_type      pop_data
);

   lcrd_pkg::job_type entry_ff [lcrd_pkg::QUEUE_DEPTH];

   logic [lcrd_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lcrd_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lcrd_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign push_ready = (count_ff != (lcrd_pkg::QUEUE_AW+1)'(lcrd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/lcrd_back.sv */
`default_nettype none

module lcrd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire lcrd_pkg::job_type job_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lcrd_pkg::rsp_type      rsp_data
);

   lcrd_pkg::job_type job_ff, job_in;
   logic              busy_ff, busy_in;
   logic [2:0]        step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   lcrd_pkg::rsp_type out_ff, out_in;
   logic              out_free;
   logic              emit;
   logic              last_pad;
   logic              finish;
   logic              take;

   // Index of the final pad write of a kind
   function automatic logic [2:0] last_step_of(input lcrd_pkg::kind_type kind);
      case (kind)
         lcrd_pkg::KIND_SINGLE: last_step_of = 3'd0;
         lcrd_pkg::KIND_PAIR:   last_step_of = 3'd1;
         lcrd_pkg::KIND_QUAD:   last_step_of = 3'd3;
         default:               last_step_of = 3'd7;
      endcase
   endfunction

   // Pad number of write k of a position byte
   function automatic logic [5:0] pad_of(input lcrd_pkg::kind_type kind,
                                         input logic [7:0] x,
                                         input logic [2:0] k);
      logic [5:0] m;
      logic [5:0] col;
      m   = ~x[5:0];
      col = x[5:0] & (x[2] ? 6'h23 : 6'h03);
      case (kind)
         lcrd_pkg::KIND_COL: pad_of = col | {1'b0, k, 2'b00};
         // row order: column by column, low half then high half within each
         lcrd_pkg::KIND_ROW: pad_of = {k[0], x[2:0], k[2:1]};
         default: begin
            case (k[1:0])
               2'd0:    pad_of = x[5:0];
               2'd1:    pad_of = m;
               2'd2:    pad_of = (x[5:0] & 6'h1C) | (m & 6'h03);
               default: pad_of = (x[5:0] & 6'h23) | (m & 6'h1C);
            endcase
         end
      endcase
   endfunction

   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit      = busy_ff && out_free;
   assign last_pad  = (step_ff == last_step_of(job_ff.kind));
   assign finish    = emit && last_pad;
   assign job_ready = !busy_ff || finish;
   assign take      = job_valid && job_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Job holder and step counter
   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (take) begin
         job_in  = job_data;
         busy_in = 1'b1;
         step_in = 3'd0;
      end else if (finish) begin
         busy_in = 1'b0;
         step_in = 3'd0;
      end else if (emit) begin
         step_in = step_ff + 3'd1;
      end
   end

   // Output register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in.pad_index   = pad_of(job_ff.kind, job_ff.pos_byte, step_ff);
         out_in.red_level   = job_ff.red_level;
         out_in.green_level = job_ff.green_level;
         out_in.blue_level  = job_ff.blue_level;
         out_in.last_of_run = last_pad;
         out_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

/* src/led_color_run_decoder.sv */
// A position byte passes the queue, the expander's job holder and its output register
// before its first pad write shows on rsp. The expander gives one pad write per cycle
// while rsp_ready holds. A position byte gives 1, 2, 4 or 8, color and count bytes none.
// A 4-entry queue between parser and expander absorbs bursts of bytes.
// Reset (synchronous, active high) returns the parser to the red byte, empties the queue
// and drops any pending pad write.
`default_nettype none

module led_color_run_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lcrd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lcrd_pkg::rsp_type      rsp_data
);

   logic              push_valid;
   logic              push_ready;
   lcrd_pkg::job_type push_data;
   logic              job_valid;
   logic              job_ready;
   lcrd_pkg::job_type job_data;

   // Byte parser
   lcrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Position queue
   lcrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job_data)
   );

   // Pad expander
   lcrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* src/lcrd_checker.sv */
`default_nettype none
`include "led_color_run_decoder_macros.svh"

module lcrd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire lcrd_pkg::rsp_type rsp_data
);

   logic levels_ok;

   // Drive levels are 0 or 2..65 on every channel
   assign levels_ok = (rsp_data.red_level != 7'd1) && (rsp_data.red_level <= 7'd65) &&
                      (rsp_data.green_level != 7'd1) && (rsp_data.green_level <= 7'd65) &&
                      (rsp_data.blue_level != 7'd1) && (rsp_data.blue_level <= 7'd65);

   // A stalled pad write stays offered
   `LCRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")

   // A stalled pad write keeps its payload
   `LCRD_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp changed")

   `LCRD_ASSERT_SAME(a_levels, rsp_valid, levels_ok, "bad level")

   // Inside a run the next pad write follows without a gap
   `LCRD_ASSERT_NEXT(a_run_gapless, rsp_valid && rsp_ready && !rsp_data.last_of_run, rsp_valid, "gap in run")

endmodule

bind led_color_run_decoder lcrd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
